// ===== design/cuov_pkg.sv =====
// ----------------------------------------------------------------------------
// Cursor overlay compositor package
// Shared sizes, register and type codes, and the structures passed between
// the address stage, the shape store and the pixel blend stage.
// ----------------------------------------------------------------------------
package cuov_pkg;

   localparam int SHAPE_WORDS    = 4096;
   localparam int MAX_CURSOR_DIM = 64;

   localparam int WORD_AW  = $clog2(SHAPE_WORDS);
   localparam int BYTE_AW  = WORD_AW + 2;
   localparam int DIM_W    = $clog2(MAX_CURSOR_DIM);
   localparam int COORD_W  = 12;
   localparam int POS_W    = 13;
   localparam int OFS_W    = POS_W + 1;
   localparam int LIM_W    = OFS_W - 1;
   localparam int PITCH_W  = 9;
   localparam int XROW_W   = ((DIM_W > 8) ? DIM_W : 8) + 1;
   localparam int AROW_W   = DIM_W + PITCH_W;
   localparam int XPROD_W  = XROW_W + PITCH_W;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 13;

   localparam logic [LIM_W-1:0] MAX_DIM_LIM = LIM_W'(MAX_CURSOR_DIM);

   localparam logic [CSR_AW-1:0] REG_CURSOR_X       = 3'd0;
   localparam logic [CSR_AW-1:0] REG_CURSOR_Y       = 3'd1;
   localparam logic [CSR_AW-1:0] REG_CURSOR_WIDTH   = 3'd2;
   localparam logic [CSR_AW-1:0] REG_CURSOR_HEIGHT  = 3'd3;
   localparam logic [CSR_AW-1:0] REG_CURSOR_PITCH   = 3'd4;
   localparam logic [CSR_AW-1:0] REG_CURSOR_TYPE    = 3'd5;
   localparam logic [CSR_AW-1:0] REG_CURSOR_VISIBLE = 3'd6;

   localparam logic [1:0] TYPE_NONE   = 2'd0;
   localparam logic [1:0] TYPE_COLOR  = 2'd1;
   localparam logic [1:0] TYPE_MASKED = 2'd2;
   localparam logic [1:0] TYPE_MONO   = 2'd3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic [7:0] BYTE_FULL = 8'hFF;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [6:0]       width;
      logic [7:0]       height;
      logic [8:0]       pitch;
      logic [1:0]       ctype;
      logic             visible;
   } cfg_type;

   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      logic [7:0] a;
   } pixel_type;

   typedef struct packed {
      logic               wr_en;
      logic [WORD_AW-1:0] wr_addr;
      logic [31:0]        wr_data;
      logic               rd_en;
      logic [WORD_AW-1:0] rd_addr0;
      logic [WORD_AW-1:0] rd_addr1;
   } store_req_type;

   typedef struct packed {
      pixel_type  pix;
      logic       in_box;
      logic [1:0] ctype;
      logic [1:0] color_ofs;
      logic [1:0] and_ofs;
      logic [1:0] xor_ofs;
      logic [2:0] bit_sel;
   } fetch_type;

endpackage

// ===== design/cursor_overlay_compositor_unit.sv =====
// ----------------------------------------------------------------------------
// Cursor overlay compositor
// Streams BGRA screen pixels past a hardware cursor held in a shape store.
// ----------------------------------------------------------------------------
// The block takes one item per clock while req_stall is low: a shape load
// (cmd 0) writes one 32-bit word of the shape store and returns nothing, a
// screen pixel (cmd 1) returns one result item, which passes stages a, b, c
// and d into stage e on the rsp port. Items are processed strictly in
// order, so a pixel sees every load accepted before it. The rate is set by the
// shape store, which serves one write or one pair of word reads per clock; a
// pixel reads two words, the shape bytes straddling a word boundary for the
// color types, or the AND and XOR mask words for monochrome. Entries of the
// store hold no defined value until written, and there is no clearing pass
// after reset. The pipeline keeps accepting items while a result waits, until
// its stages are full. Registers are to be written through the csr port only
// while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cursor_overlay_compositor_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [11:0]                 req_word_index,
   input  logic [31:0]                 req_shape_word,
   input  logic [11:0]                 req_pixel_x,
   input  logic [11:0]                 req_pixel_y,
   input  logic [7:0]                  req_pix_b,
   input  logic [7:0]                  req_pix_g,
   input  logic [7:0]                  req_pix_r,
   input  logic [7:0]                  req_pix_a,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_b,
   output logic [7:0]                  rsp_out_g,
   output logic [7:0]                  rsp_out_r,
   output logic [7:0]                  rsp_out_a,
   output logic                        rsp_cursor_hit,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cuov_pkg::CSR_AW-1:0] csr_index,
   input  logic [cuov_pkg::CSR_DW-1:0] csr_wdata
);
   import cuov_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   store_req_type store_req;
   fetch_type     fetch;
   logic          c_ready;
   logic [31:0]   rd_data0, rd_data1;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CURSOR_X:       cfg_in.x       = csr_wdata;
            REG_CURSOR_Y:       cfg_in.y       = csr_wdata;
            REG_CURSOR_WIDTH:   cfg_in.width   = csr_wdata[6:0];
            REG_CURSOR_HEIGHT:  cfg_in.height  = csr_wdata[7:0];
            REG_CURSOR_PITCH:   cfg_in.pitch   = csr_wdata[8:0];
            REG_CURSOR_TYPE:    cfg_in.ctype   = csr_wdata[1:0];
            REG_CURSOR_VISIBLE: cfg_in.visible = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cuov_addr u_addr (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_word_index (req_word_index),
      .req_shape_word (req_shape_word),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_pix_b      (req_pix_b),
      .req_pix_g      (req_pix_g),
      .req_pix_r      (req_pix_r),
      .req_pix_a      (req_pix_a),
      .c_ready        (c_ready),
      .store_req      (store_req),
      .fetch          (fetch)
   );

   cuov_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data0  (rd_data0),
      .rd_data1  (rd_data1)
   );

   cuov_blend u_blend (
      .clock          (clock),
      .reset          (reset),
      .fetch          (fetch),
      .fetch_go       (store_req.rd_en),
      .rd_data0       (rd_data0),
      .rd_data1       (rd_data1),
      .c_ready        (c_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_b      (rsp_out_b),
      .rsp_out_g      (rsp_out_g),
      .rsp_out_r      (rsp_out_r),
      .rsp_out_a      (rsp_out_a),
      .rsp_cursor_hit (rsp_cursor_hit)
   );

endmodule

// ===== design/cuov_addr.sv =====
// ----------------------------------------------------------------------------
// Cursor overlay address stage
// Takes input items, finds the pixel's place in the cursor box and forms the
// shape store word addresses; issues shape loads and pixel reads in order.
// ----------------------------------------------------------------------------
module cuov_addr (
   input  logic                         clock,
   input  logic                         reset,
   input  cuov_pkg::cfg_type            cfg,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [11:0]                  req_word_index,
   input  logic [31:0]                  req_shape_word,
   input  logic [cuov_pkg::COORD_W-1:0] req_pixel_x,
   input  logic [cuov_pkg::COORD_W-1:0] req_pixel_y,
   input  logic [7:0]                   req_pix_b,
   input  logic [7:0]                   req_pix_g,
   input  logic [7:0]                   req_pix_r,
   input  logic [7:0]                   req_pix_a,
   input  logic                         c_ready,
   output cuov_pkg::store_req_type      store_req,
   output cuov_pkg::fetch_type          fetch
);
   import cuov_pkg::*;

   logic               a_valid_ff, a_valid_in;
   logic               a_cmd_ff;
   logic [11:0]        a_word_index_ff;
   logic [31:0]        a_shape_word_ff;
   logic [OFS_W-1:0]   a_cx_ff, a_cx_in;
   logic [OFS_W-1:0]   a_cy_ff, a_cy_in;
   pixel_type          a_pix_ff;

   logic               b_valid_ff, b_valid_in;
   logic               b_cmd_ff;
   logic               b_wr_ok_ff, b_wr_ok_in;
   logic [WORD_AW-1:0] b_waddr_ff, b_waddr_in;
   logic [31:0]        b_wdata_ff;
   logic [WORD_AW-1:0] b_rd0_ff, b_rd0_in;
   logic [WORD_AW-1:0] b_rd1_ff, b_rd1_in;
   fetch_type          b_fetch_ff, b_fetch_in;

   logic               a_ready, accept, b_ready, b_take, b_leave;
   logic               inside_x, inside_y, active;
   logic [7:0]         rows;
   logic [DIM_W-1:0]   ux, uy;
   logic [XROW_W-1:0]  xrow;
   logic [AROW_W-1:0]  row_prod, and_sum, color_sum;
   logic [XPROD_W-1:0] xrow_prod, xor_sum;
   logic [BYTE_AW-1:0] and_byte, xor_byte, color_byte;
   logic [WORD_AW-1:0] color_word;

   assign b_ready   = !b_valid_ff || (b_cmd_ff == CMD_LOAD) || c_ready;
   assign b_leave   = b_valid_ff && ((b_cmd_ff == CMD_LOAD) || c_ready);
   assign a_ready   = !a_valid_ff || b_ready;
   assign b_take    = a_valid_ff && b_ready;
   assign accept    = req_valid && a_ready;
   assign req_stall = !a_ready;

   assign a_cx_in = {{(OFS_W-COORD_W){1'b0}}, req_pixel_x} - {cfg.x[POS_W-1], cfg.x};
   assign a_cy_in = {{(OFS_W-COORD_W){1'b0}}, req_pixel_y} - {cfg.y[POS_W-1], cfg.y};

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (b_take) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      if (b_take) begin
         b_valid_in = 1'b1;
      end else if (b_leave) begin
         b_valid_in = 1'b0;
      end
   end

   assign rows     = (cfg.ctype == TYPE_MONO) ? {1'b0, cfg.height[7:1]} : cfg.height;
   assign active   = cfg.visible && (cfg.ctype != TYPE_NONE);
   assign inside_x = !a_cx_ff[OFS_W-1] && (a_cx_ff[LIM_W-1:0] < LIM_W'(cfg.width))
                     && (a_cx_ff[LIM_W-1:0] < MAX_DIM_LIM);
   assign inside_y = !a_cy_ff[OFS_W-1] && (a_cy_ff[LIM_W-1:0] < LIM_W'(rows))
                     && (a_cy_ff[LIM_W-1:0] < MAX_DIM_LIM);
   assign ux = a_cx_ff[DIM_W-1:0];
   assign uy = a_cy_ff[DIM_W-1:0];

   assign xrow       = XROW_W'(rows) + XROW_W'(uy);
   assign row_prod   = uy * cfg.pitch;
   assign xrow_prod  = xrow * cfg.pitch;
   assign and_sum    = row_prod + AROW_W'(ux >> 3);
   assign color_sum  = row_prod + AROW_W'({ux, 2'b00});
   assign xor_sum    = xrow_prod + XPROD_W'(ux >> 3);
   assign and_byte   = BYTE_AW'(and_sum);
   assign color_byte = BYTE_AW'(color_sum);
   assign xor_byte   = BYTE_AW'(xor_sum);
   assign color_word = color_byte[BYTE_AW-1:2];

   always_comb begin
      b_wr_ok_in = (32'(a_word_index_ff) < 32'(SHAPE_WORDS));
      b_waddr_in = WORD_AW'(a_word_index_ff);
      if (rows == 8'd0 && cfg.ctype == TYPE_NONE) begin
         b_rd0_in = color_word;
      end else if (cfg.ctype == TYPE_MONO) begin
         b_rd0_in = and_byte[BYTE_AW-1:2];
      end else begin
         b_rd0_in = color_word;
      end
      if (cfg.ctype == TYPE_MONO) begin
         b_rd1_in = xor_byte[BYTE_AW-1:2];
      end else begin
         b_rd1_in = color_word + 1'b1;
      end
      b_fetch_in.pix       = a_pix_ff;
      b_fetch_in.in_box    = active && inside_x && inside_y;
      b_fetch_in.ctype     = cfg.ctype;
      b_fetch_in.color_ofs = color_byte[1:0];
      b_fetch_in.and_ofs   = and_byte[1:0];
      b_fetch_in.xor_ofs   = xor_byte[1:0];
      b_fetch_in.bit_sel   = ux[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff        <= req_cmd;
         a_word_index_ff <= req_word_index;
         a_shape_word_ff <= req_shape_word;
         a_cx_ff         <= a_cx_in;
         a_cy_ff         <= a_cy_in;
         a_pix_ff        <= '{b: req_pix_b, g: req_pix_g, r: req_pix_r, a: req_pix_a};
      end
      if (b_take) begin
         b_cmd_ff   <= a_cmd_ff;
         b_wr_ok_ff <= b_wr_ok_in;
         b_waddr_ff <= b_waddr_in;
         b_wdata_ff <= a_shape_word_ff;
         b_rd0_ff   <= b_rd0_in;
         b_rd1_ff   <= b_rd1_in;
         b_fetch_ff <= b_fetch_in;
      end
   end

   assign store_req.wr_en    = b_leave && (b_cmd_ff == CMD_LOAD) && b_wr_ok_ff;
   assign store_req.wr_addr  = b_waddr_ff;
   assign store_req.wr_data  = b_wdata_ff;
   assign store_req.rd_en    = b_leave && (b_cmd_ff == CMD_PIXEL);
   assign store_req.rd_addr0 = b_rd0_ff;
   assign store_req.rd_addr1 = b_rd1_ff;
   assign fetch              = b_fetch_ff;

endmodule

// ===== design/cuov_store.sv =====
// ----------------------------------------------------------------------------
// Cursor overlay shape store
// Shape word memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module cuov_store (
   input  logic                    clock,
   input  cuov_pkg::store_req_type store_req,
   output logic [31:0]             rd_data0,
   output logic [31:0]             rd_data1
);
   import cuov_pkg::*;

   logic [31:0] mem [SHAPE_WORDS];
   logic [31:0] rd_data0_ff, rd_data1_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data0_ff <= mem[store_req.rd_addr0];
         rd_data1_ff <= mem[store_req.rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// ===== design/cuov_blend.sv =====
// ----------------------------------------------------------------------------
// Cursor overlay blend stage
// Picks the shape bytes or mask bits from the store words, applies the cursor
// type to the screen pixel and holds the result item for the output.
// ----------------------------------------------------------------------------
module cuov_blend (
   input  logic                clock,
   input  logic                reset,
   input  cuov_pkg::fetch_type fetch,
   input  logic                fetch_go,
   input  logic [31:0]         rd_data0,
   input  logic [31:0]         rd_data1,
   output logic                c_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_b,
   output logic [7:0]          rsp_out_g,
   output logic [7:0]          rsp_out_r,
   output logic [7:0]          rsp_out_a,
   output logic                rsp_cursor_hit
);
   import cuov_pkg::*;

   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [16:0] t;
      t = 17'(n) + 17'(n[15:8]) + 17'd1;
      return t[15:8];
   endfunction

   logic        c_valid_ff, c_valid_in;
   fetch_type   c_fetch_ff;
   logic        d_valid_ff, d_valid_in;
   logic        d_blend_ff, d_blend_in;
   logic        d_hit_ff, d_hit_in;
   pixel_type   d_direct_ff, d_direct_in;
   logic [15:0] d_sum_b_ff, d_sum_b_in;
   logic [15:0] d_sum_g_ff, d_sum_g_in;
   logic [15:0] d_sum_r_ff, d_sum_r_in;
   logic        e_valid_ff, e_valid_in;
   pixel_type   e_pix_ff, e_pix_in;
   logic        e_hit_ff;

   logic        e_ready, d_ready, c_leave, d_leave;
   logic [63:0] pair_sh;
   logic [31:0] and_sh, xor_sh;
   logic [7:0]  and_byte, xor_byte, sb, sg, sr, sa, inv_a;
   logic        and_bit, xor_bit;
   pixel_type   dpix;

   assign e_ready = !e_valid_ff || !rsp_stall;
   assign d_ready = !d_valid_ff || e_ready;
   assign c_ready = !c_valid_ff || d_ready;
   assign c_leave = c_valid_ff && d_ready;
   assign d_leave = d_valid_ff && e_ready;

   always_comb begin
      c_valid_in = c_valid_ff;
      if (fetch_go) begin
         c_valid_in = 1'b1;
      end else if (c_leave) begin
         c_valid_in = 1'b0;
      end
      d_valid_in = d_valid_ff;
      if (c_leave) begin
         d_valid_in = 1'b1;
      end else if (d_leave) begin
         d_valid_in = 1'b0;
      end
      e_valid_in = e_valid_ff;
      if (d_leave) begin
         e_valid_in = 1'b1;
      end else if (e_valid_ff && !rsp_stall) begin
         e_valid_in = 1'b0;
      end
   end

   assign dpix     = c_fetch_ff.pix;
   assign pair_sh  = {rd_data1, rd_data0} >> {c_fetch_ff.color_ofs, 3'b000};
   assign sb       = pair_sh[7:0];
   assign sg       = pair_sh[15:8];
   assign sr       = pair_sh[23:16];
   assign sa       = pair_sh[31:24];
   assign inv_a    = ~sa;
   assign and_sh   = rd_data0 >> {c_fetch_ff.and_ofs, 3'b000};
   assign xor_sh   = rd_data1 >> {c_fetch_ff.xor_ofs, 3'b000};
   assign and_byte = and_sh[7:0];
   assign xor_byte = xor_sh[7:0];
   assign and_bit  = and_byte[3'd7 - c_fetch_ff.bit_sel];
   assign xor_bit  = xor_byte[3'd7 - c_fetch_ff.bit_sel];

   assign d_sum_b_in = sb * sa + dpix.b * inv_a;
   assign d_sum_g_in = sg * sa + dpix.g * inv_a;
   assign d_sum_r_in = sr * sa + dpix.r * inv_a;

   always_comb begin
      d_blend_in  = 1'b0;
      d_hit_in    = 1'b0;
      d_direct_in = dpix;
      if (c_fetch_ff.in_box) begin
         case (c_fetch_ff.ctype)
            TYPE_COLOR: begin
               d_hit_in   = (sa != 8'd0);
               d_blend_in = (sa != 8'd0);
            end
            TYPE_MASKED: begin
               d_hit_in = 1'b1;
               if (sa == 8'd0) begin
                  d_direct_in.b = sb;
                  d_direct_in.g = sg;
                  d_direct_in.r = sr;
               end else begin
                  d_direct_in.b = dpix.b ^ sb;
                  d_direct_in.g = dpix.g ^ sg;
                  d_direct_in.r = dpix.r ^ sr;
               end
            end
            TYPE_MONO: begin
               if (!and_bit) begin
                  d_hit_in      = 1'b1;
                  d_direct_in.b = xor_bit ? BYTE_FULL : 8'd0;
                  d_direct_in.g = xor_bit ? BYTE_FULL : 8'd0;
                  d_direct_in.r = xor_bit ? BYTE_FULL : 8'd0;
               end else if (xor_bit) begin
                  d_hit_in      = 1'b1;
                  d_direct_in.b = ~dpix.b;
                  d_direct_in.g = ~dpix.g;
                  d_direct_in.r = ~dpix.r;
               end
            end
            default: begin
               d_hit_in = 1'b0;
            end
         endcase
      end
      if (d_hit_in) begin
         d_direct_in.a = BYTE_FULL;
      end
   end

   always_comb begin
      e_pix_in = d_direct_ff;
      if (d_blend_ff) begin
         e_pix_in.b = div255(d_sum_b_ff);
         e_pix_in.g = div255(d_sum_g_ff);
         e_pix_in.r = div255(d_sum_r_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_go) begin
         c_fetch_ff <= fetch;
      end
      if (c_leave) begin
         d_blend_ff  <= d_blend_in;
         d_hit_ff    <= d_hit_in;
         d_direct_ff <= d_direct_in;
         d_sum_b_ff  <= d_sum_b_in;
         d_sum_g_ff  <= d_sum_g_in;
         d_sum_r_ff  <= d_sum_r_in;
      end
      if (d_leave) begin
         e_pix_ff <= e_pix_in;
         e_hit_ff <= d_hit_ff;
      end
   end

   assign rsp_valid      = e_valid_ff;
   assign rsp_out_b      = e_pix_ff.b;
   assign rsp_out_g      = e_pix_ff.g;
   assign rsp_out_r      = e_pix_ff.r;
   assign rsp_out_a      = e_pix_ff.a;
   assign rsp_cursor_hit = e_hit_ff;

endmodule
